FILE: design/riff_data_chunk_extractor_unit_assert.svh
// Assertion macros used by the RIFF data chunk extractor parser.
`ifndef RIFF_DATA_CHUNK_EXTRACTOR_UNIT_ASSERT_SVH
`define RIFF_DATA_CHUNK_EXTRACTOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define RDCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define RDCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rdce_pkg.sv
// Shared widths, codes, tags and transfer types of the RIFF data chunk extractor.
`default_nettype none

package rdce_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FILE_LEN_W = 32;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned POS_W      = 33;
  localparam int unsigned REM_W      = 33;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_PAYLOAD    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_HEADER = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERRUN    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_DATA    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY_DATA = 3'd4;

  // Four-character codes, first character in the top byte.
  localparam logic [31:0] RIFF_TAG = 32'h5249_4646;
  localparam logic [31:0] WAVE_TAG = 32'h5741_5645;
  localparam logic [31:0] DATA_ID  = 32'h6461_7461;

  // Chunk header length: four id bytes and four size bytes.
  localparam logic [REM_W-1:0] CHUNK_HDR_LEN = 33'd8;

  // One input item.
  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              first_byte;
  } byte_item_t;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0]   payload_byte;
    logic                last_payload;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

`default_nettype wire

FILE: design/rdce_byte_if.sv
// Valid/ready channel that carries file bytes into the extractor.
`default_nettype none

interface rdce_byte_if;
  import rdce_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              first_byte;

  modport source (output valid, output byte_value, output first_byte, input ready);
  modport sink (input valid, input byte_value, input first_byte, output ready);
endinterface

`default_nettype wire

FILE: design/rdce_result_if.sv
// Valid/ready channel that carries payload bytes and status results out.
`default_nettype none

interface rdce_result_if;
  import rdce_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   payload_byte;
  logic                last_payload;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output payload_byte, output last_payload, output status,
                  input ready);
  modport sink (input valid, input payload_byte, input last_payload, input status,
                output ready);
endinterface

`default_nettype wire

FILE: design/rdce_in_reg.sv
// Input register that captures one byte transfer ahead of the parser.
`default_nettype none

module rdce_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  rdce_byte_if.sink           in_i,
  input  logic                take_i,
  output logic                vld_o,
  output rdce_pkg::byte_item_t item_o
);
  import rdce_pkg::*;

  logic       vld_q, vld_d;
  byte_item_t item_q;
  logic       accept;

  // The register frees up in the same cycle the parser consumes it.
  assign in_i.ready = !vld_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload capture needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.byte_value <= in_i.byte_value;
      item_q.first_byte <= in_i.first_byte;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;
endmodule

`default_nettype wire

FILE: design/rdce_parser.sv
// Parser state and per-byte decision logic of the RIFF data chunk extractor.
`default_nettype none
`include "riff_data_chunk_extractor_unit_assert.svh"

module rdce_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                file_length_we_i,
  input  logic [rdce_pkg::FILE_LEN_W-1:0]     file_length_i,
  input  logic                                vld_i,
  input  rdce_pkg::byte_item_t                item_i,
  input  logic                                out_free_i,
  output logic                                take_o,
  output logic                                res_vld_o,
  output rdce_pkg::result_t                   res_o
);
  import rdce_pkg::*;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_CHUNK   = 5'b00010,
    PH_SKIP    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_e;

  // Picks byte idx of a four-character code, idx 0 being the first character.
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    logic [31:0] shifted;
    shifted  = tag >> {~idx, 3'b000};
    tag_byte = shifted[7:0];
  endfunction

  logic [FILE_LEN_W-1:0] file_length_q;
  phase_e                phase_q, phase_d, cur_phase;
  logic [POS_W-1:0]      pos_q, pos_d, cur_pos;
  logic [31:0]           id_q, id_d, cur_id;
  logic [31:0]           size_q, size_d, cur_size;
  logic [REM_W-1:0]      rem_q, rem_d, cur_rem;

  logic                  fire;
  logic                  end_chk;
  logic [POS_W:0]        pos_p1;
  logic [POS_W:0]        fl_ext;
  logic [31:0]           id_shifted;
  logic [31:0]           size_shifted;
  logic [REM_W-1:0]      rem_dec;
  logic [REM_W-1:0]      skip_len;
  logic                  overrun;
  logic [BYTE_W-1:0]     b;
  logic                  res_vld;
  result_t               res;

  // A byte is processed once the result register has room for its result.
  assign fire   = vld_i && out_free_i;
  assign take_o = fire;
  assign b      = item_i.byte_value;

  always_comb begin
    // A first byte restarts parsing from a clean state.
    cur_phase = item_i.first_byte ? PH_HEADER : phase_q;
    cur_pos   = item_i.first_byte ? '0 : pos_q;
    cur_id    = item_i.first_byte ? '0 : id_q;
    cur_size  = item_i.first_byte ? '0 : size_q;
    cur_rem   = item_i.first_byte ? '0 : rem_q;

    phase_d = cur_phase;
    pos_d   = cur_pos;
    id_d    = cur_id;
    size_d  = cur_size;
    rem_d   = cur_rem;
    res_vld = 1'b0;
    res     = '0;
    end_chk = 1'b0;

    pos_p1       = {1'b0, cur_pos} + {{POS_W{1'b0}}, 1'b1};
    fl_ext       = {{(POS_W + 1 - FILE_LEN_W){1'b0}}, file_length_q};
    id_shifted   = {cur_id[23:0], b};
    size_shifted = {b, cur_size[31:8]};
    rem_dec      = cur_rem - {{(REM_W-1){1'b0}}, (cur_rem != '0)};
    skip_len     = {1'b0, size_shifted} + {{(REM_W-1){1'b0}}, size_shifted[0]};
    // Chunk body must fit in what is left of the file after this byte.
    overrun      = ({{(POS_W + 1 - 32){1'b0}}, size_shifted} + pos_p1) > fl_ext;

    if (cur_phase != PH_DONE) begin
      if (cur_phase != PH_PAYLOAD && {1'b0, cur_pos} >= fl_ext) begin
        // Byte at or past the file end: report what the end implies.
        res_vld    = 1'b1;
        res.status = (cur_phase == PH_HEADER) ? ST_BAD_HEADER : ST_NO_DATA;
        phase_d    = PH_DONE;
      end else begin
        pos_d   = (&cur_pos) ? cur_pos : pos_p1[POS_W-1:0];
        end_chk = 1'b1;
        case (cur_phase)
          PH_HEADER: begin
            if (cur_pos < 33'd4) begin
              if (b != tag_byte(RIFF_TAG, cur_pos[1:0])) begin
                res_vld    = 1'b1;
                res.status = ST_BAD_HEADER;
                phase_d    = PH_DONE;
                end_chk    = 1'b0;
              end
            end else if (cur_pos >= 33'd8 && cur_pos < 33'd12) begin
              if (b != tag_byte(WAVE_TAG, cur_pos[1:0])) begin
                res_vld    = 1'b1;
                res.status = ST_BAD_HEADER;
                phase_d    = PH_DONE;
                end_chk    = 1'b0;
              end else if (cur_pos == 33'd11) begin
                phase_d = PH_CHUNK;
                rem_d   = CHUNK_HDR_LEN;
              end
            end
          end
          PH_CHUNK: begin
            // Id bytes shift in from the low end, size bytes little-endian.
            if (cur_rem > 33'd4) begin
              id_d = id_shifted;
            end else begin
              size_d = size_shifted;
            end
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              if (overrun) begin
                res_vld    = 1'b1;
                res.status = ST_OVERRUN;
                phase_d    = PH_DONE;
                end_chk    = 1'b0;
              end else if (cur_id == DATA_ID) begin
                if (size_shifted == '0) begin
                  res_vld    = 1'b1;
                  res.status = ST_EMPTY_DATA;
                  phase_d    = PH_DONE;
                  end_chk    = 1'b0;
                end else begin
                  phase_d = PH_PAYLOAD;
                  rem_d   = {1'b0, size_shifted};
                end
              end else if (skip_len == '0) begin
                rem_d = CHUNK_HDR_LEN;
              end else begin
                phase_d = PH_SKIP;
                rem_d   = skip_len;
              end
            end
          end
          PH_SKIP: begin
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              phase_d = PH_CHUNK;
              rem_d   = CHUNK_HDR_LEN;
            end
          end
          PH_PAYLOAD: begin
            // Payload bytes go out regardless of the file length.
            end_chk          = 1'b0;
            res_vld          = 1'b1;
            res.payload_byte = b;
            res.status       = ST_PAYLOAD;
            if (cur_rem <= 33'd1) begin
              res.last_payload = 1'b1;
              rem_d            = '0;
              phase_d          = PH_DONE;
            end else begin
              rem_d = rem_dec;
            end
          end
          default: begin
            end_chk = 1'b0;
          end
        endcase
      end
    end

    // This byte was the last of the file.
    if (end_chk && pos_p1 >= fl_ext) begin
      res_vld    = 1'b1;
      res.status = (phase_d == PH_HEADER) ? ST_BAD_HEADER : ST_NO_DATA;
      phase_d    = PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_length_q <= '0;
    end else if (file_length_we_i) begin
      file_length_q <= file_length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      id_q    <= '0;
      size_q  <= '0;
      rem_q   <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      id_q    <= id_d;
      size_q  <= size_d;
      rem_q   <= rem_d;
    end
  end

  assign res_vld_o = fire && res_vld;
  assign res_o     = res;

  `RDCE_ASSERT_NEXT(a_final_result_ends_parse, fire && res_vld && (res.status != ST_PAYLOAD || res.last_payload), phase_q == PH_DONE, "final result did not end the parse")
  `RDCE_ASSERT_NOW(a_done_is_silent, fire && !item_i.first_byte && phase_q == PH_DONE, !res_vld_o, "result produced after the parse ended")
  `RDCE_ASSERT_NOW(a_payload_byte_out, fire && !item_i.first_byte && phase_q == PH_PAYLOAD, res_vld_o && res.status == ST_PAYLOAD, "payload byte gave no payload result")
  `RDCE_ASSERT_NOW(a_skip_has_bytes, phase_q == PH_SKIP, rem_q != '0, "skip phase with nothing left to skip")
endmodule

`default_nettype wire

FILE: design/rdce_out_reg.sv
// Result register that holds one result transfer until the sink takes it.
`default_nettype none

module rdce_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_vld_i,
  input  rdce_pkg::result_t res_i,
  output logic              free_o,
  rdce_result_if.source     out_o
);
  import rdce_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  // Room for a new result when empty or when the held one leaves this cycle.
  assign free_o = !vld_q || out_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (res_vld_i) begin
      vld_d = 1'b1;
    end else if (out_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = vld_q;
  assign out_o.payload_byte = res_q.payload_byte;
  assign out_o.last_payload = res_q.last_payload;
  assign out_o.status       = res_q.status;
endmodule

`default_nettype wire

FILE: design/riff_data_chunk_extractor_unit.sv
// Top level of the RIFF/WAVE data chunk extractor.
//
//   Channel   Direction  Carries                                 Transfer when
//   in_i      in         byte_value, first_byte                  valid && ready
//   out_o     out        payload_byte, last_payload, status      valid && ready
//   file_len  in         file_length_i (write only)              file_length_we_i
//
// One byte per clock sustained while the result side keeps taking results.
// A byte passes the input register, one pass of parser logic and the result register to its result.
// Reset clears the parser to the header check and file_length to zero.
// A stalled result blocks the parser, which in turn holds the input register.
`default_nettype none

module riff_data_chunk_extractor_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            file_length_we_i,
  input  logic [rdce_pkg::FILE_LEN_W-1:0] file_length_i,
  rdce_byte_if.sink                       in_i,
  rdce_result_if.source                   out_o
);
  import rdce_pkg::*;

  logic       item_vld;
  byte_item_t item;
  logic       take;
  logic       out_free;
  logic       res_vld;
  result_t    res;

  rdce_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .take_i (take),
    .vld_o  (item_vld),
    .item_o (item)
  );

  rdce_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .file_length_we_i (file_length_we_i),
    .file_length_i    (file_length_i),
    .vld_i            (item_vld),
    .item_i           (item),
    .out_free_i       (out_free),
    .take_o           (take),
    .res_vld_o        (res_vld),
    .res_o            (res)
  );

  rdce_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_vld_i (res_vld),
    .res_i     (res),
    .free_o    (out_free),
    .out_o     (out_o)
  );
endmodule

`default_nettype wire

FILE: dv/tb_riff_data_chunk_extractor_unit.sv
// Self-checking testbench for the RIFF/WAVE data chunk extractor top level.
`timescale 1ns / 1ps

module tb_riff_data_chunk_extractor_unit;
  import rdce_pkg::*;

  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned SETTLE_CYC  = 6;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_ITEMS_PER_PHASE = 500;
  localparam logic [POS_W-1:0] POS_LIMIT = {POS_W{1'b1}};
  localparam logic [31:0] FMT_ID  = 32'h666d_7420;
  localparam logic [31:0] LIST_ID = 32'h4c49_5354;

  typedef enum logic [2:0] {
    PARSE_HEADER,
    PARSE_CHUNK,
    PARSE_SKIP,
    PARSE_PAYLOAD,
    PARSE_DONE
  } parse_phase_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  file_length_we_i;
  logic [FILE_LEN_W-1:0] file_length_i;

  rdce_byte_if   byte_ch ();
  rdce_result_if res_ch ();

  riff_data_chunk_extractor_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .file_length_we_i (file_length_we_i),
    .file_length_i    (file_length_i),
    .in_i             (byte_ch),
    .out_o            (res_ch)
  );

  // Parser state as the testbench sees it.
  parse_phase_e          parser_phase;
  logic [POS_W-1:0]      parser_pos;
  logic [31:0]           parser_id;
  logic [31:0]           parser_size;
  logic [REM_W-1:0]      parser_left;
  logic [FILE_LEN_W-1:0] file_len_model;

  result_t     expected_results[$];
  logic [7:0]  file_bytes[$];
  logic [31:0] rand_flen;

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Run-length guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_parser();
    parser_phase = PARSE_HEADER;
    parser_pos   = '0;
    parser_id    = '0;
    parser_size  = '0;
    parser_left  = '0;
  endfunction

  function automatic void push_result(input logic [7:0] b, input logic last,
                                      input logic [STATUS_W-1:0] st);
    result_t r;
    r.payload_byte = b;
    r.last_payload = last;
    r.status       = st;
    expected_results.push_back(r);
  endfunction

  // The file ran out: the status depends on whether the header was complete.
  function automatic void end_of_file();
    push_result(8'h00, 1'b0, (parser_phase == PARSE_HEADER) ? ST_BAD_HEADER : ST_NO_DATA);
    parser_phase = PARSE_DONE;
  endfunction

  // Works out the result, if any, that one accepted byte causes.
  function automatic void parse_byte(input byte_item_t item);
    logic [63:0] p;
    logic [63:0] avail;
    logic [63:0] skip;
    logic [7:0]  b;
    int          k;
    b = item.byte_value;
    if (item.first_byte) clear_parser();
    if (parser_phase == PARSE_DONE) return;
    p = {31'b0, parser_pos};
    if (parser_phase != PARSE_PAYLOAD && p >= {32'b0, file_len_model}) begin
      end_of_file();
      return;
    end
    if (parser_pos != POS_LIMIT) parser_pos = parser_pos + 1'b1;

    case (parser_phase)
      PARSE_HEADER: begin
        if (p < 4) begin
          k = int'(p);
          if (b != RIFF_TAG[8*(3-k) +: 8]) begin
            parser_phase = PARSE_DONE;
            push_result(8'h00, 1'b0, ST_BAD_HEADER);
            return;
          end
        end else if (p >= 8 && p < 12) begin
          k = int'(p) - 8;
          if (b != WAVE_TAG[8*(3-k) +: 8]) begin
            parser_phase = PARSE_DONE;
            push_result(8'h00, 1'b0, ST_BAD_HEADER);
            return;
          end
          if (p == 11) begin
            parser_phase = PARSE_CHUNK;
            parser_left  = CHUNK_HDR_LEN;
          end
        end
      end
      PARSE_CHUNK: begin
        if (parser_left > 4) parser_id = {parser_id[23:0], b};
        else parser_size = {b, parser_size[31:8]};
        if (parser_left > 0) parser_left = parser_left - 1'b1;
        if (parser_left == 0) begin
          avail = {32'b0, file_len_model} - (p + 1);
          if ({32'b0, parser_size} > avail) begin
            parser_phase = PARSE_DONE;
            push_result(8'h00, 1'b0, ST_OVERRUN);
            return;
          end
          if (parser_id == DATA_ID) begin
            if (parser_size == 0) begin
              parser_phase = PARSE_DONE;
              push_result(8'h00, 1'b0, ST_EMPTY_DATA);
              return;
            end
            parser_phase = PARSE_PAYLOAD;
            parser_left  = {1'b0, parser_size};
          end else begin
            // Odd-sized bodies carry one pad byte.
            skip = {32'b0, parser_size} + parser_size[0];
            if (skip == 0) begin
              parser_left = CHUNK_HDR_LEN;
            end else begin
              parser_phase = PARSE_SKIP;
              parser_left  = skip[REM_W-1:0];
            end
          end
        end
      end
      PARSE_SKIP: begin
        if (parser_left > 0) parser_left = parser_left - 1'b1;
        if (parser_left == 0) begin
          parser_phase = PARSE_CHUNK;
          parser_left  = CHUNK_HDR_LEN;
        end
      end
      default: begin
        // Payload runs to its full size regardless of the file length.
        if (parser_left <= 1) begin
          parser_left  = '0;
          parser_phase = PARSE_DONE;
          push_result(b, 1'b1, ST_PAYLOAD);
          return;
        end
        parser_left = parser_left - 1'b1;
        push_result(b, 1'b0, ST_PAYLOAD);
        return;
      end
    endcase

    if (p + 1 >= {32'b0, file_len_model}) end_of_file();
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready pattern and checking
  // ---------------------------------------------------------------------------

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: payload_byte %0h last_payload %0b status %0d",
               res_ch.payload_byte, res_ch.last_payload, res_ch.status);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_ch.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0h, actual %0h", want.payload_byte,
                 res_ch.payload_byte);
          error_count++;
        end
        if (res_ch.last_payload !== want.last_payload) begin
          $error("last_payload: expected %0b, actual %0b", want.last_payload,
                 res_ch.last_payload);
          error_count++;
        end
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, res_ch.status);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte side and configuration
  // ---------------------------------------------------------------------------

  // Offers one byte, with random idle cycles first, and waits for its transfer.
  task automatic send_byte(input logic [7:0] b, input logic fb);
    byte_item_t item;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.byte_value <= b;
    byte_ch.first_byte <= fb;
    do @(posedge clk_i); while (!byte_ch.ready);
    item.byte_value = b;
    item.first_byte = fb;
    parse_byte(item);
    items_sent++;
  endtask

  // Stops offering, waits for every expected result, then lets the pipe empty.
  task automatic drain_results();
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Writes the file length register; only called while the block is idle.
  task automatic write_file_length(input logic [31:0] len);
    @(negedge clk_i);
    file_length_we_i <= 1'b1;
    file_length_i    <= len;
    @(negedge clk_i);
    file_length_we_i <= 1'b0;
    file_len_model = len;
  endtask

  // Sends the bytes built up in file_bytes, optionally pausing for results mid-file.
  task automatic send_file(input logic mark_first, input int unsigned pause_pct);
    for (int i = 0; i < file_bytes.size(); i++) begin
      if (i > 0 && $urandom_range(0, 999) < pause_pct) drain_results();
      send_byte(file_bytes[i], mark_first && (i == 0));
    end
  endtask

  // File builders.
  task automatic push_tag(input logic [31:0] tag);
    for (int k = 0; k < 4; k++) file_bytes.push_back(tag[8*(3-k) +: 8]);
  endtask

  task automatic push_size(input logic [31:0] sz);
    for (int k = 0; k < 4; k++) file_bytes.push_back(sz[8*k +: 8]);
  endtask

  task automatic push_random(input int unsigned n);
    for (int k = 0; k < n; k++) file_bytes.push_back(8'($urandom));
  endtask

  task automatic start_wave_file();
    file_bytes.delete();
    push_tag(RIFF_TAG);
    push_random(4);
    push_tag(WAVE_TAG);
  endtask

  task automatic push_other_chunk(input logic [31:0] sz);
    logic [31:0] id;
    case ($urandom_range(0, 3))
      0:       id = FMT_ID;
      1:       id = LIST_ID;
      2:       id = {DATA_ID[31:8], 8'($urandom)};
      default: id = $urandom;
    endcase
    push_tag(id);
    push_size(sz);
    push_random(sz + sz[0]);
  endtask

  task automatic build_wave_file(input int unsigned n_other, input logic [31:0] data_size);
    start_wave_file();
    for (int c = 0; c < n_other; c++) push_other_chunk($urandom_range(0, 9));
    push_tag(DATA_ID);
    push_size(data_size);
    push_random(data_size);
    push_random($urandom_range(0, 3));
  endtask

  // Picks one random file: mostly well formed, the rest broken or noise.
  task automatic build_random_file();
    int unsigned kind;
    int unsigned sel;
    int unsigned idx;
    logic [31:0] dsize;
    kind = $urandom_range(0, 99);
    dsize = ($urandom_range(0, 19) == 0) ? 32'd0 : 32'($urandom_range(1, 48));
    if (kind < 70) begin
      build_wave_file($urandom_range(0, 3), dsize);
      sel = $urandom_range(0, 19);
      if (sel < 14)      rand_flen = file_bytes.size();
      else if (sel < 17) rand_flen = $urandom_range(0, file_bytes.size() - 1);
      else if (sel < 18) rand_flen = 32'hFFFF_FFFF;
      else               rand_flen = file_bytes.size() + $urandom_range(1, 20);
    end else if (kind < 80) begin
      build_wave_file($urandom_range(0, 2), dsize);
      idx = $urandom_range(0, file_bytes.size() - 1);
      file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
      rand_flen = file_bytes.size();
    end else if (kind < 88) begin
      start_wave_file();
      if ($urandom_range(0, 1)) push_other_chunk($urandom_range(0, 5));
      push_tag(($urandom_range(0, 1) == 0) ? DATA_ID : LIST_ID);
      push_size($urandom | 32'h0000_0100);
      push_random($urandom_range(0, 4));
      rand_flen = file_bytes.size();
    end else if (kind < 94) begin
      start_wave_file();
      for (int c = $urandom_range(0, 3); c > 0; c--) push_other_chunk($urandom_range(0, 9));
      rand_flen = file_bytes.size() + (($urandom_range(0, 3) == 0) ? 3 : 0);
    end else begin
      file_bytes.delete();
      push_random($urandom_range(1, 30));
      rand_flen = $urandom_range(0, 1) ? 32'($urandom_range(0, 40)) : $urandom;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset the length is zero and no start flag has been seen.
  task automatic test_reset_defaults();
    send_byte(8'h52, 1'b0);
    send_byte(8'h49, 1'b0);
    drain_results();
  endtask

  task automatic test_header_errors();
    // Mismatch on byte zero with the largest length.
    write_file_length(32'hFFFF_FFFF);
    send_byte(8'h58, 1'b1);
    send_byte(8'hFF, 1'b0);
    drain_results();
    // File ends inside the header.
    write_file_length(32'd5);
    file_bytes.delete();
    push_tag(RIFF_TAG);
    push_random(1);
    send_file(1'b1, 0);
    drain_results();
    // Mismatch in the form tag.
    write_file_length(32'd12);
    file_bytes.delete();
    push_tag(RIFF_TAG);
    push_random(4);
    push_tag(32'h5741_5658);
    send_file(1'b1, 0);
    drain_results();
  endtask

  // An odd-sized chunk with its pad byte is skipped before the data payload.
  task automatic test_payload_walk();
    start_wave_file();
    push_tag(FMT_ID);
    push_size(32'd3);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'hA5);
    file_bytes.push_back(8'h5A);
    push_tag(DATA_ID);
    push_size(32'd2);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00);
    write_file_length(file_bytes.size());
    send_file(1'b1, 0);
    drain_results();
  endtask

  task automatic test_chunk_errors();
    // Chunk size past the file end.
    start_wave_file();
    push_tag(LIST_ID);
    push_size(32'd100);
    write_file_length(file_bytes.size());
    send_file(1'b1, 0);
    drain_results();
    // Data chunk with nothing in it.
    start_wave_file();
    push_tag(DATA_ID);
    push_size(32'd0);
    write_file_length(file_bytes.size());
    send_file(1'b1, 0);
    drain_results();
    // No data chunk before the file ends.
    start_wave_file();
    write_file_length(file_bytes.size());
    send_file(1'b1, 0);
    drain_results();
  endtask

  // The length register drops to zero while the payload is under way.
  task automatic test_length_change();
    start_wave_file();
    push_tag(DATA_ID);
    push_size(32'd4);
    file_bytes.push_back(8'h11);
    write_file_length(32'd24);
    send_file(1'b1, 0);
    drain_results();
    write_file_length(32'd0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b0);
    drain_results();
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    build_wave_file(1, 32'd64);
    write_file_length(file_bytes.size());
    hold_cycles = 300;
    send_file(1'b1, 0);
    drain_results();
  endtask

  task automatic test_random_files();
    int unsigned target;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      target = items_sent + RANDOM_ITEMS_PER_PHASE;
      while (items_sent < target) begin
        build_random_file();
        write_file_length(rand_flen);
        send_file($urandom_range(0, 19) != 0, 10);
        drain_results();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni             = 1'b0;
    file_length_we_i   = 1'b0;
    file_length_i      = '0;
    byte_ch.valid      = 1'b0;
    byte_ch.byte_value = '0;
    byte_ch.first_byte = 1'b0;
    cycle_count        = 0;
    error_count        = 0;
    items_sent         = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_cycles        = 0;
    file_len_model     = '0;
    clear_parser();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_header_errors();
    test_payload_walk();
    test_chunk_errors();
    test_length_change();
    test_backpressure();
    test_random_files();

    drain_results();
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/rdce_pkg.sv
design/rdce_byte_if.sv
design/rdce_result_if.sv
design/rdce_in_reg.sv
design/rdce_parser.sv
design/rdce_out_reg.sv
design/riff_data_chunk_extractor_unit.sv
dv/tb_riff_data_chunk_extractor_unit.sv
